// ===== design/idlpd_pkg.sv =====
// ----------------------------------------------------------------------------
// idlpd_pkg - shared types and constants for the id/length deframer
// Phase and result-kind codes, the result record and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package idlpd_pkg;

  // Header field sizes in bytes (each 1 or 2)
  localparam int unsigned ID_BYTES_DEF  = 2;
  localparam int unsigned LEN_BYTES_DEF = 2;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned BYTE_W = 8;

  localparam logic [15:0] LIMIT_RESET = 16'd2048;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    message_id;
    logic [BYTE_W-1:0]  payload_byte;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

// ===== design/id_length_prefixed_deframer.sv =====
// ----------------------------------------------------------------------------
// id_length_prefixed_deframer - length-prefixed message deframer with id
// Collects a big-endian id and length header from a byte stream, passes the
// payload bytes through tagged with the id, and reports framing/link errors.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake           payload
//   -------  ---------  ------------------  ------------------------------------
//   in       input      in_valid/in_stall   in_rx_byte, in_link_error
//   out      output     out_valid/out_stall out_kind, out_message_id,
//                                           out_payload_byte, out_last
//   cfg      input      cfg_wr_en           cfg_wr_data (size limit)
//
// One byte is taken per clock while in_stall is low; each accepted result is
// registered into the output register, or into the skid register behind it
// while the output stalls. The skid register absorbs one result, so in_stall
// rises only when both are full. rst_n (synchronous, active low) returns to the
// header phase and sets the size limit to 2048. After an error the block
// swallows every byte until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module id_length_prefixed_deframer #(
  parameter int unsigned ID_BYTES  = idlpd_pkg::ID_BYTES_DEF,
  parameter int unsigned LEN_BYTES = idlpd_pkg::LEN_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_link_error,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_message_id,
  output logic [7:0]       out_payload_byte,
  output logic             out_last
);

  localparam int unsigned HDR_BYTES = ID_BYTES + LEN_BYTES;
  localparam int unsigned HDR_W     = 8 * HDR_BYTES;
  localparam int unsigned LEN_W     = 8 * LEN_BYTES;
  localparam int unsigned CNT_W     = $clog2(HDR_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HDR_BYTES - 1);

  // Configuration
  logic [15:0] size_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_limit_r <= idlpd_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      size_limit_r <= cfg_wr_data;
    end
  end

  // Deframer state
  idlpd_pkg::phase_t phase_r, phase_nxt;
  logic [CNT_W-1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [HDR_W-9:0]  hdr_shift_r, hdr_shift_nxt;
  logic [15:0]       cur_id_r, cur_id_nxt;
  logic [15:0]       remaining_r, remaining_nxt;

  logic              in_accept;
  logic [HDR_W-1:0]  hdr_full;
  logic [15:0]       hdr_id;
  logic [15:0]       hdr_len;
  logic              hdr_done;
  logic              hdr_bad;
  logic              pay_last;

  assign in_accept = in_valid && !in_stall;

  // Header as it stands once this byte is shifted in
  assign hdr_full = {hdr_shift_r, in_rx_byte};
  assign hdr_len  = 16'(hdr_full[LEN_W-1:0]);
  assign hdr_id   = 16'(hdr_full[HDR_W-1:LEN_W]);
  assign hdr_done = (hdr_cnt_r == CNT_LAST);
  assign hdr_bad  = (hdr_id > size_limit_r) || (hdr_len > size_limit_r);
  assign pay_last = (remaining_r <= 16'd1);

  // Next state
  always_comb begin
    phase_nxt     = phase_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    hdr_shift_nxt = hdr_shift_r;
    cur_id_nxt    = cur_id_r;
    remaining_nxt = remaining_r;
    if (in_accept) begin
      case (phase_r)
        idlpd_pkg::PH_HEADER: begin
          if (in_link_error) begin
            phase_nxt = idlpd_pkg::PH_ERROR;
          end else if (!hdr_done) begin
            hdr_shift_nxt = hdr_full[HDR_W-9:0];
            hdr_cnt_nxt   = hdr_cnt_r + 1'b1;
          end else begin
            hdr_shift_nxt = '0;
            hdr_cnt_nxt   = '0;
            if (hdr_bad) begin
              phase_nxt = idlpd_pkg::PH_ERROR;
            end else begin
              cur_id_nxt = hdr_id;
              if (hdr_len != 16'd0) begin
                remaining_nxt = hdr_len;
                phase_nxt     = idlpd_pkg::PH_PAYLOAD;
              end
            end
          end
        end
        idlpd_pkg::PH_PAYLOAD: begin
          if (in_link_error) begin
            phase_nxt = idlpd_pkg::PH_ERROR;
          end else if (pay_last) begin
            remaining_nxt = '0;
            phase_nxt     = idlpd_pkg::PH_HEADER;
          end else begin
            remaining_nxt = remaining_r - 16'd1;
          end
        end
        default: begin
          // error phase: drop everything until reset
        end
      endcase
    end
  end

  // Result of the accepted byte
  logic                res_valid;
  idlpd_pkg::result_t  res;

  always_comb begin
    res_valid        = 1'b0;
    res.kind         = idlpd_pkg::KIND_ERROR;
    res.message_id   = cur_id_r;
    res.payload_byte = '0;
    res.last         = 1'b0;
    if (in_accept) begin
      case (phase_r)
        idlpd_pkg::PH_HEADER: begin
          if (in_link_error || (hdr_done && hdr_bad)) begin
            res_valid = 1'b1;
          end else if (hdr_done && (hdr_len == 16'd0)) begin
            res_valid      = 1'b1;
            res.kind       = idlpd_pkg::KIND_EMPTY;
            res.message_id = hdr_id;
            res.last       = 1'b1;
          end
        end
        idlpd_pkg::PH_PAYLOAD: begin
          res_valid = 1'b1;
          if (!in_link_error) begin
            res.kind         = idlpd_pkg::KIND_DATA;
            res.payload_byte = in_rx_byte;
            res.last         = pay_last;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= idlpd_pkg::PH_HEADER;
      hdr_cnt_r   <= '0;
      hdr_shift_r <= '0;
      cur_id_r    <= '0;
      remaining_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      hdr_shift_r <= hdr_shift_nxt;
      cur_id_r    <= cur_id_nxt;
      remaining_r <= remaining_nxt;
    end
  end

  // Output register with one skid entry behind it
  logic                out_valid_r, out_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  idlpd_pkg::result_t  out_r, out_nxt;
  idlpd_pkg::result_t  skid_r, skid_nxt;
  logic                out_free;

  // Output register can load when empty or when its transfer completes now
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        // no byte is taken while the skid entry is full
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = res_valid;
      end
    end else if (res_valid) begin
      // hold the output, park the new result
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign in_stall         = skid_valid_r;
  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_message_id   = out_r.message_id;
  assign out_payload_byte = out_r.payload_byte;
  assign out_last         = out_r.last;

endmodule

`default_nettype wire
